/* rtl/core/tseq_pkg.sv */
// Shared types and constants for the time-sorted event queue.
`default_nettype none
package tseq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_CNT_W   = 6;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        evt_id;
    logic [31:0]        event_time;
    logic [2:0]         evt_kind;
    logic signed [31:0] event_priority;
    logic [7:0]         event_task;
    logic [7:0]         event_resource;
    logic [3:0]         event_processor;
  } cmd_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [15:0]          out_id;
    logic [31:0]          out_time;
    logic [2:0]           out_type;
    logic signed [31:0]   out_priority;
    logic [7:0]           out_task;
    logic [7:0]           out_resource;
    logic [3:0]           out_processor;
    logic [OUT_CNT_W-1:0] entry_count;
  } result_t;

  // One stored event.
  typedef struct packed {
    logic [15:0]        id;
    logic [2:0]         etype;
    logic [7:0]         etask;
    logic [7:0]         eres;
    logic [3:0]         eproc;
    logic [31:0]        etime;
    logic signed [31:0] eprio;
  } entry_t;

endpackage
`default_nettype wire

/* rtl/core/tseq_ram.sv */
// Simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none
module tseq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* rtl/core/time_sorted_event_queue.sv */
// Top level of the time-sorted event queue: control sequencer around the entry RAM.
//
//   port group           dir  meaning
//   start/busy/cmd       in   command beat, taken when start and not busy
//   done/result          out  one result beat per command, one cycle, no stall
//   wr_en/wr_data        in   finish type code register write
//
// Errors and unused opcodes are answered from idle. Insert scans from the
// head one entry a cycle until it finds its place p, then moves the n-p
// entries behind it back one a cycle. Pop and delete scan to the entry
// (pop: slot 0) and move the rest forward; a delete that misses scans to
// the end. The single RAM read port is why entries move one at a time.
// Reset (rst, synchronous) clears the count and the register; the RAM
// holds no valid data until written and its contents are only used below
// the count. Results cannot be stalled.
`default_nettype none
module time_sorted_event_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire tseq_pkg::cmd_t   cmd,
  output logic                  done,
  output tseq_pkg::result_t     result,
  input  wire logic             wr_en,
  input  wire logic [2:0]       wr_data
);
  import tseq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SHPRE  = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_FIND   = 3'd4;
  localparam logic [2:0] S_RSHIFT = 3'd5;

  logic [2:0]       state;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] wptr;
  logic [CNT_W-1:0] place;
  logic [1:0]       phase;
  logic [2:0]       fin_code;
  cmd_t             cur;
  entry_t           removed;

  // RAM port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rbits;
  entry_t            rd;

  tseq_ram #(.WIDTH($bits(entry_t)), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rbits)
  );

  assign rd   = entry_t'(ram_rbits);
  assign busy = (state != S_IDLE);

  entry_t new_entry;
  assign new_entry = '{id: cur.evt_id, etype: cur.evt_kind, etask: cur.event_task,
                       eres: cur.event_resource, eproc: cur.event_processor,
                       etime: cur.event_time, eprio: cur.event_priority};

  // Insert ordering: does the entry just read stay ahead of the new one
  logic       teq, tlt, efin, nfin;
  logic       adv;
  logic [1:0] phase_next;

  always_comb begin
    teq  = (rd.etime == cur.event_time);
    tlt  = (rd.etime < cur.event_time);
    efin = (rd.etype == fin_code);
    nfin = (cur.evt_kind == fin_code);
    adv  = 1'b1;
    phase_next = phase;
    if (phase == 2'd0 && tlt) begin
      phase_next = 2'd0;
    end else if (phase <= 2'd1 && teq && efin) begin
      phase_next = 2'd1;
    end else if (!nfin && phase <= 2'd2 && teq && rd.etype < cur.evt_kind) begin
      phase_next = 2'd2;
    end else if (!nfin && teq && rd.eprio <= cur.event_priority) begin
      phase_next = 2'd3;
    end else begin
      adv = 1'b0;
    end
  end

  logic id_hit;
  assign id_hit = (cur.opcode == OP_POP) || (rd.id == cur.evt_id);

  // RAM addressing and write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wptr[ADDR_W-1:0];
    ram_wdata = rd;
    ram_raddr = '0;
    case (state)
      S_SCAN, S_FIND: begin
        ram_raddr = ADDR_W'(ptr + 1'b1);
      end
      S_SHPRE: begin
        ram_raddr = ADDR_W'(cnt - 1'b1);
      end
      S_SHIFT: begin
        ram_raddr = ADDR_W'(wptr - 2'd2);
        ram_we    = 1'b1;
        if (wptr == place) begin
          ram_wdata = new_entry;
        end
      end
      S_RSHIFT: begin
        ram_raddr = ADDR_W'(wptr + 2'd2);
        ram_we    = (CNT_W'(wptr + 1'b1) < cnt);
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  result_t res_next;
  logic    fire;

  always_comb begin
    res_next = '0;
    fire     = 1'b0;
    res_next.entry_count = OUT_CNT_W'(cnt);
    case (state)
      S_IDLE: begin
        if (start) begin
          if (cmd.opcode == OP_INSERT) begin
            if (cnt == CNT_W'(QUEUE_DEPTH)) begin
              fire = 1'b1;
              res_next.status = ST_FULL;
            end
          end else if (cmd.opcode inside {OP_POP, OP_DELETE}) begin
            if (cnt == '0) begin
              fire = 1'b1;
              res_next.status = ST_EMPTY;
            end
          end else begin
            fire = 1'b1;
          end
        end
      end
      S_SHIFT: begin
        if (wptr == place) begin
          fire = 1'b1;
          res_next.entry_count = OUT_CNT_W'(cnt + 1'b1);
        end
      end
      S_FIND: begin
        if (ptr == cnt) begin
          fire = 1'b1;
          res_next.status = ST_NOT_FOUND;
        end
      end
      S_RSHIFT: begin
        if (CNT_W'(wptr + 1'b1) >= cnt) begin
          fire = 1'b1;
          res_next.out_id        = removed.id;
          res_next.out_time      = removed.etime;
          res_next.out_type      = removed.etype;
          res_next.out_priority  = removed.eprio;
          res_next.out_task      = removed.etask;
          res_next.out_resource  = removed.eres;
          res_next.out_processor = removed.eproc;
          res_next.entry_count   = OUT_CNT_W'(cnt - 1'b1);
        end
      end
      default: begin
        fire = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      fin_code <= '0;
      done     <= 1'b0;
    end else begin
      done <= fire;
      if (wr_en) begin
        fin_code <= wr_data;
      end
      case (state)
        S_IDLE: begin
          if (start && !fire) begin
            cur   <= cmd;
            ptr   <= '0;
            phase <= 2'd0;
            state <= (cmd.opcode == OP_INSERT) ? S_SCAN : S_FIND;
          end
        end
        S_SCAN: begin
          if (ptr == cnt || !adv) begin
            place <= ptr;
            state <= S_SHPRE;
          end else begin
            ptr   <= CNT_W'(ptr + 1'b1);
            phase <= phase_next;
          end
        end
        S_SHPRE: begin
          wptr  <= cnt;
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (wptr == place) begin
            cnt   <= CNT_W'(cnt + 1'b1);
            state <= S_IDLE;
          end else begin
            wptr <= CNT_W'(wptr - 1'b1);
          end
        end
        S_FIND: begin
          if (ptr == cnt) begin
            state <= S_IDLE;
          end else if (id_hit) begin
            removed <= rd;
            wptr    <= ptr;
            state   <= S_RSHIFT;
          end else begin
            ptr <= CNT_W'(ptr + 1'b1);
          end
        end
        S_RSHIFT: begin
          if (CNT_W'(wptr + 1'b1) >= cnt) begin
            cnt   <= CNT_W'(cnt - 1'b1);
            state <= S_IDLE;
          end else begin
            wptr <= CNT_W'(wptr + 1'b1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* dv/time_sorted_event_queue_tb.sv */
// Self-checking testbench for the time-sorted event queue: ordering, pop, delete and errors.
`default_nettype none
module time_sorted_event_queue_tb;
  import tseq_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  // Scoreboard: mirrors the queue contents and holds the results still owed.
  class event_queue_scoreboard;
    entry_t    slots[$];
    logic [2:0] finish_code;
    result_t   owed[$];
    int        errors;
    int        checked;

    function new();
      finish_code = 3'd0;
      errors      = 0;
      checked     = 0;
    endfunction

    // Slot at which a new event lands, walking from the head.
    function int landing_slot(cmd_t c);
      int p;
      p = 0;
      while (p < slots.size() && slots[p].etime < c.event_time) p++;
      while (p < slots.size() && slots[p].etime == c.event_time &&
             slots[p].etype == finish_code) p++;
      if (c.evt_kind != finish_code) begin
        while (p < slots.size() && slots[p].etime == c.event_time &&
               slots[p].etype < c.evt_kind) p++;
        while (p < slots.size() && slots[p].etime == c.event_time &&
               slots[p].eprio <= c.event_priority) p++;
      end
      return p;
    endfunction

    // Note an accepted command beat and queue up the result it owes.
    function void note_command(cmd_t c);
      result_t r;
      entry_t  e;
      int      s;
      r = '0;
      r.status = ST_OK;
      if (c.opcode == OP_INSERT) begin
        if (slots.size() >= QUEUE_DEPTH) r.status = ST_FULL;
        else begin
          e.id    = c.evt_id;          e.etype = c.evt_kind;
          e.etask = c.event_task;      e.eres  = c.event_resource;
          e.eproc = c.event_processor; e.etime = c.event_time;
          e.eprio = c.event_priority;
          slots.insert(landing_slot(c), e);
        end
      end else if (c.opcode == OP_POP || c.opcode == OP_DELETE) begin
        if (slots.size() == 0) r.status = ST_EMPTY;
        else begin
          s = 0;
          if (c.opcode == OP_DELETE)
            while (s < slots.size() && slots[s].id != c.evt_id) s++;
          if (s >= slots.size()) r.status = ST_NOT_FOUND;
          else begin
            r.out_id       = slots[s].id;    r.out_time     = slots[s].etime;
            r.out_type     = slots[s].etype; r.out_priority = slots[s].eprio;
            r.out_task     = slots[s].etask; r.out_resource = slots[s].eres;
            r.out_processor = slots[s].eproc;
            slots.delete(s);
          end
        end
      end
      r.entry_count = OUT_CNT_W'(slots.size());
      owed.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t x;
      if (owed.size() == 0) begin
        $error("result beat with nothing outstanding");
        errors++;
        return;
      end
      x = owed.pop_front();
      checked++;
      if (got.status !== x.status) begin
        $error("status exp %0d got %0d", x.status, got.status); errors++;
      end
      if (got.out_id !== x.out_id) begin
        $error("out_id exp %0h got %0h", x.out_id, got.out_id); errors++;
      end
      if (got.out_time !== x.out_time) begin
        $error("out_time exp %0h got %0h", x.out_time, got.out_time); errors++;
      end
      if (got.out_type !== x.out_type) begin
        $error("out_type exp %0d got %0d", x.out_type, got.out_type); errors++;
      end
      if (got.out_priority !== x.out_priority) begin
        $error("out_priority exp %0d got %0d", x.out_priority, got.out_priority); errors++;
      end
      if (got.out_task !== x.out_task) begin
        $error("out_task exp %0d got %0d", x.out_task, got.out_task); errors++;
      end
      if (got.out_resource !== x.out_resource) begin
        $error("out_resource exp %0d got %0d", x.out_resource, got.out_resource); errors++;
      end
      if (got.out_processor !== x.out_processor) begin
        $error("out_processor exp %0d got %0d", x.out_processor, got.out_processor);
        errors++;
      end
      if (got.entry_count !== x.entry_count) begin
        $error("entry_count exp %0d got %0d", x.entry_count, got.entry_count); errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  cmd_t       cmd = '0;
  logic       done;
  result_t    result;
  logic       wr_en = 1'b0;
  logic [2:0] wr_data = 3'd0;

  event_queue_scoreboard board = new();
  int  quiet_cycles;
  int  beats_sent;

  time_sorted_event_queue dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .done    (done),
    .result  (result),
    .wr_en   (wr_en),
    .wr_data (wr_data)
  );

  always #5 clk = ~clk;

  // Sample at the rising edge: accepted commands into the scoreboard, result beats checked.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (start && !busy) board.note_command(cmd);
      if (done) board.check_result(result);
      if ((start && !busy) || done) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: a long stretch with no beat either way means the block has hung.
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(negedge clk);
  endtask

  // Drive one command beat; start drops after acceptance.
  task automatic send_command(cmd_t c);
    @(negedge clk);
    cmd   <= c;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start <= 1'b0;
    cmd   <= '0;
    beats_sent++;
    idle_gap();
  endtask

  // Drain outstanding results, then a settling pause before touching the register.
  task automatic wait_idle();
    while (board.owed.size() != 0) @(posedge clk);
    repeat (QUEUE_DEPTH + 8) @(negedge clk);
  endtask

  task automatic write_finish_code(logic [2:0] code);
    @(negedge clk);
    wr_en   <= 1'b1;
    wr_data <= code;
    @(negedge clk);
    wr_en   <= 1'b0;
    board.finish_code = code;
  endtask

  function automatic cmd_t make_insert(logic [15:0] id, logic [31:0] t, logic [2:0] ty,
                                       logic signed [31:0] pr);
    cmd_t c;
    c = '0;
    c.opcode = OP_INSERT;
    c.evt_id = id; c.event_time = t; c.evt_kind = ty; c.event_priority = pr;
    c.event_task = 8'($urandom); c.event_resource = 8'($urandom);
    c.event_processor = 4'($urandom);
    return c;
  endfunction

  function automatic cmd_t make_op(logic [1:0] op, logic [15:0] id);
    cmd_t c;
    c = '0;
    c.opcode = op;
    c.evt_id = id;
    c.event_time = {$urandom}; c.event_priority = $urandom;
    return c;
  endfunction

  // Random command: a small time window and id pool so ties and delete hits happen.
  function automatic cmd_t random_command(int mode);
    cmd_t c;
    int   r;
    logic [31:0] t;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: t = $urandom;
      1: t = $urandom_range(0, 3);
      2: t = 32'hFFFF_FFFF - $urandom_range(0, 2);
      default: t = $urandom_range(100, 103);
    endcase
    if (($urandom_range(0, 1) == 0) && (board.slots.size() > 0))
      t = board.slots[$urandom_range(0, board.slots.size() - 1)].etime;
    c = make_insert(16'($urandom_range(0, 15)), t, 3'($urandom),
                    ($urandom_range(0, 1) ? $signed($urandom_range(0, 6)) - 3 : $urandom));
    if ($urandom_range(0, 7) == 0) c.evt_id = 16'($urandom);
    // mode 0 fills, mode 1 drains, mode 2 mixes
    if (mode == 1) begin
      if (r < 20) return c;
      c.opcode = (r < 60) ? OP_POP : OP_DELETE;
    end else if (mode == 0) begin
      if (r < 85) return c;
      c.opcode = (r < 93) ? OP_POP : OP_DELETE;
    end else begin
      if (r < 45) return c;
      c.opcode = (r < 70) ? OP_POP : (r < 97) ? OP_DELETE : OP_UNUSED;
    end
    return c;
  endfunction

  initial begin
    logic [2:0] codes[4];
    int mode;
    beats_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty errors, extremes, tie ordering, full queue, missing id, opcode 3.
    send_command(make_op(OP_POP, 16'h0));
    send_command(make_op(OP_DELETE, 16'hFFFF));
    send_command(make_op(OP_UNUSED, 16'h1234));
    wait_idle();
    write_finish_code(3'd7);
    send_command(make_insert(16'hFFFF, 32'hFFFF_FFFF, 3'd7, 32'sh7FFF_FFFF));
    send_command(make_insert(16'h0000, 32'h0, 3'd0, -32'sh8000_0000));
    send_command(make_insert(16'h0001, 32'd50, 3'd3, 32'sd5));
    send_command(make_insert(16'h0002, 32'd50, 3'd7, 32'sd9));  // finish goes first
    send_command(make_insert(16'h0003, 32'd50, 3'd1, 32'sd9));  // lands behind lower prio
    send_command(make_insert(16'h0004, 32'd50, 3'd3, 32'sd5));  // equal prio goes after
    send_command(make_insert(16'h0005, 32'd50, 3'd3, -32'sd1));
    send_command(make_insert(16'h0006, 32'd50, 3'd7, 32'sd0));
    send_command(make_op(OP_DELETE, 16'h0004));
    send_command(make_op(OP_DELETE, 16'hBEEF));
    send_command(make_op(OP_POP, 16'h0));
    // Enough inserts to fill the queue and run into the full error a few times.
    repeat (QUEUE_DEPTH + 2)
      send_command(make_insert(16'($urandom), 32'($urandom_range(0, 5)), 3'($urandom),
                               $urandom));
    while (board.slots.size() > 0 || board.owed.size() > 0) begin
      if (board.owed.size() == 0 && board.slots.size() == 0) break;
      send_command(make_op(OP_POP, 16'h0));
      if (board.slots.size() == 0) break;
    end
    wait_idle();

    // Random phases across several register settings, extremes included.
    codes[0] = 3'd0; codes[1] = 3'd7; codes[2] = 3'($urandom); codes[3] = 3'd3;
    for (int ph = 0; ph < 4; ph++) begin
      write_finish_code(codes[ph]);
      for (int k = 0; k < 200; k++) begin
        mode = (k % 60 < 30) ? 0 : (k % 60 < 45) ? 2 : 1;
        send_command(random_command(mode));
      end
      wait_idle();
    end

    $display("Covered %0d commands, %0d results checked, finish codes 0, 7 and others.",
             beats_sent, board.checked);
    $display("Includes tie ordering, full and empty queues, missing ids and the unused opcode.");
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
`default_nettype wire
